FILE: rtl/core/rss_pkg.sv
// shared types, constants and functions of the rss flow hash and queue select unit
package rss_pkg;

  localparam int BUCKETS    = 128;               // power of two
  localparam int BUCKET_W   = $clog2(BUCKETS);
  localparam int SPLIT      = BUCKET_W / 2;      // remainder bits done in the last stage
  localparam int MAX_QUEUES = 16;
  localparam int NQ_W       = 5;
  localparam int Q_W        = 4;
  localparam int KEY_WORDS  = 4;
  localparam int HDR_WORDS  = 3;

  localparam int IN_DATA_W  = 96;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;
  localparam int ADDR_W     = 5;

  // register indexes
  localparam logic [2:0] REG_NUM_QUEUES = 3'd0;
  localparam logic [2:0] REG_KEY_WORD0  = 3'd1;
  localparam logic [2:0] REG_KEY_WORD1  = 3'd2;
  localparam logic [2:0] REG_KEY_WORD2  = 3'd3;
  localparam logic [2:0] REG_KEY_WORD3  = 3'd4;

  localparam logic [NQ_W-1:0] NUM_QUEUES_RST = NQ_W'(4);
  localparam logic [31:0] KEY_WORD0_RST = 32'h3a42624c;
  localparam logic [31:0] KEY_WORD1_RST = 32'h41a926fc;
  localparam logic [31:0] KEY_WORD2_RST = 32'h5adf32f8;
  localparam logic [31:0] KEY_WORD3_RST = 32'h2944c283;

  // packet classes
  localparam logic [1:0] CLASS_NON_IP = 2'd0;
  localparam logic [1:0] CLASS_TCP    = 2'd1;
  localparam logic [1:0] CLASS_UDP    = 2'd2;
  localparam logic [1:0] CLASS_OTHER  = 2'd3;

  typedef struct packed {
    logic [NQ_W-1:0] num_queues;
    logic [KEY_WORDS-1:0][31:0] key;
  } cfg_t;

  // xor of the key windows picked by the set bits of one header word
  function automatic logic [31:0] toep_part(input logic [31:0] word,
                                            input logic [31:0] key_hi,
                                            input logic [31:0] key_lo);
    logic [63:0] pair;
    logic [31:0] h;
    pair = {key_hi, key_lo};
    h = '0;
    for (int j = 0; j < 32; j++) begin
      if (word[j]) begin
        h = h ^ pair[63-j -: 32];
      end
    end
    return h;
  endfunction

  // zero queues acts as one, more than the maximum acts as the maximum
  function automatic logic [NQ_W-1:0] nq_clamp(input logic [NQ_W-1:0] nq);
    logic [NQ_W-1:0] r;
    if (nq == '0) r = NQ_W'(1);
    else if (nq > NQ_W'(MAX_QUEUES)) r = NQ_W'(MAX_QUEUES);
    else r = nq;
    return r;
  endfunction

  // one restoring step of bucket % nq, remainder always below nq
  function automatic logic [Q_W-1:0] qmod_step(input logic [Q_W-1:0] r,
                                               input logic b,
                                               input logic [NQ_W-1:0] nq);
    logic [NQ_W-1:0] t;
    logic [NQ_W-1:0] d;
    t = {r, b};
    d = t - nq;
    return (t >= nq) ? d[Q_W-1:0] : t[Q_W-1:0];
  endfunction

endpackage

FILE: rtl/core/rss_flow_hash_queue_select_unit.sv
// Receive-side scaling flow hash and queue select. Each header transaction on the s_ stream
// yields one result on the m_ stream: a least-significant-bit-first Toeplitz hash of source
// address, destination address and the two L4 ports over a 128-bit key, and queue =
// (hash mod 128) mod num_queues, num_queues clamped to 1..16. Classes other than TCP and UDP
// give hash 0 and queue 0. One header is taken every cycle; the three pipeline stages
// (key window xor tree, fold plus upper remainder steps, lower remainder steps) each hold
// their item only while the stage after them is full and stalled, so throughput drops
// below one per cycle only when m_tready is low. Registers sit on a small APB port and are
// meant to be written while the stream is quiet.
module rss_flow_hash_queue_select_unit import rss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // src_addr, dst_addr, src_l4_port, dst_l4_port
  input  logic [IN_USER_W-1:0]  s_tuser,   // pkt_class
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // queue, hash, zero padding
);

  cfg_t cfg;
  logic [2:0] reg_idx;
  logic wr_en;
  logic [Q_W-1:0] queue;
  logic [31:0] hash;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_queues <= NUM_QUEUES_RST;
      cfg.key[0]     <= KEY_WORD0_RST;
      cfg.key[1]     <= KEY_WORD1_RST;
      cfg.key[2]     <= KEY_WORD2_RST;
      cfg.key[3]     <= KEY_WORD3_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NUM_QUEUES: cfg.num_queues <= pwdata[NQ_W-1:0];
        REG_KEY_WORD0:  cfg.key[0] <= pwdata;
        REG_KEY_WORD1:  cfg.key[1] <= pwdata;
        REG_KEY_WORD2:  cfg.key[2] <= pwdata;
        REG_KEY_WORD3:  cfg.key[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NUM_QUEUES: prdata = {{(32-NQ_W){1'b0}}, cfg.num_queues};
      REG_KEY_WORD0:  prdata = cfg.key[0];
      REG_KEY_WORD1:  prdata = cfg.key[1];
      REG_KEY_WORD2:  prdata = cfg.key[2];
      REG_KEY_WORD3:  prdata = cfg.key[3];
      default:        prdata = '0;
    endcase
  end

  rss_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_class    (s_tuser),
    .in_src_addr (s_tdata[31:0]),
    .in_dst_addr (s_tdata[63:32]),
    .in_src_port (s_tdata[79:64]),
    .in_dst_port (s_tdata[95:80]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_queue   (queue),
    .out_hash    (hash)
  );

  assign m_tdata = {{(OUT_DATA_W-32-Q_W){1'b0}}, hash, queue};

endmodule

FILE: rtl/core/rss_core.sv
// three-stage hash and queue select pipeline with per-stage flow control
module rss_core import rss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_class,
  input  logic [31:0]          in_src_addr,
  input  logic [31:0]          in_dst_addr,
  input  logic [15:0]          in_src_port,
  input  logic [15:0]          in_dst_port,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [Q_W-1:0]       out_queue,
  output logic [31:0]          out_hash
);

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  logic [HDR_WORDS-1:0][31:0] part;
  logic [HDR_WORDS-1:0][31:0] part_next;
  logic [31:0]    hash2;
  logic [31:0]    hash2_next;
  logic [Q_W-1:0] rem2;
  logic [Q_W-1:0] rem2_next;
  logic [31:0]    hash3;
  logic [Q_W-1:0] queue3;
  logic [Q_W-1:0] queue3_next;
  logic [NQ_W-1:0] nq;
  logic [HDR_WORDS-1:0][31:0] words;
  logic hashed;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign nq = nq_clamp(cfg.num_queues);

  // stage 1: one partial hash per header word, zero for unhashed classes
  always_comb begin
    words[0] = in_src_addr;
    words[1] = in_dst_addr;
    words[2] = {in_src_port, in_dst_port};
    hashed = (in_class == CLASS_TCP) || (in_class == CLASS_UDP);
    for (int i = 0; i < HDR_WORDS; i++) begin
      part_next[i] = hashed ? toep_part(words[i], cfg.key[i], cfg.key[i+1]) : '0;
    end
  end

  // stage 2: fold partials, upper remainder steps
  always_comb begin
    hash2_next = part[0] ^ part[1] ^ part[2];
    rem2_next = '0;
    for (int i = BUCKET_W - 1; i >= SPLIT; i--) begin
      rem2_next = qmod_step(rem2_next, hash2_next[i], nq);
    end
  end

  // stage 3: lower remainder steps
  always_comb begin
    queue3_next = rem2;
    for (int i = SPLIT - 1; i >= 0; i--) begin
      queue3_next = qmod_step(queue3_next, hash2[i], nq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) part <= part_next;
    if (rdy2 && v1) begin
      hash2 <= hash2_next;
      rem2  <= rem2_next;
    end
    if (rdy3 && v2) begin
      hash3  <= hash2;
      queue3 <= queue3_next;
    end
  end

  assign out_valid = v3;
  assign out_queue = queue3;
  assign out_hash  = hash3;

endmodule

FILE: rtl/core/rss_checker.sv
// port-level checks for the rss flow hash and queue select unit, bound to the top level
module rss_checker import rss_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // nothing left in flight after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result present after reset");

  // a remainder never exceeds the bucket it came from
  a_queue_le_bucket: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> {{(BUCKET_W-Q_W){1'b0}}, m_tdata[Q_W-1:0]} <= m_tdata[Q_W +: BUCKET_W])
    else $error("queue above bucket");

  // zero hash always lands on queue zero
  a_zero_hash: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[Q_W +: 32] == 32'd0) |-> m_tdata[Q_W-1:0] == '0)
    else $error("zero hash with non-zero queue");

endmodule

bind rss_flow_hash_queue_select_unit rss_checker u_rss_checker (.*);

FILE: bench/rss_flow_hash_queue_select_unit_tb.sv
// testbench for the rss flow hash and queue select unit: directed, swept and random headers
module rss_flow_hash_queue_select_unit_tb;
  import rss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  cls;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
  } header_t;

  typedef struct {
    logic [Q_W-1:0] queue;
    logic [31:0]    hash;
  } steer_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // src_addr, dst_addr, src_l4_port, dst_l4_port
  logic [IN_USER_W-1:0]  s_tuser;   // pkt_class
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // queue, hash, zero padding

  // shadow of the register file
  logic [NQ_W-1:0] shadow_nq;
  logic [31:0]     shadow_key [KEY_WORDS];

  steer_t steer_expected [$];
  int     error_count;
  int     rx_hold_cycles;
  bit     tx_gaps;
  bit     rx_gaps;

  rss_flow_hash_queue_select_unit uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // lsb-first toeplitz over the three header words
  function automatic logic [31:0] flow_hash(input logic [31:0] src, input logic [31:0] dst,
                                            input logic [31:0] ports);
    logic [31:0] words [HDR_WORDS];
    logic [63:0] span;
    logic [31:0] acc;
    words[0] = src;
    words[1] = dst;
    words[2] = ports;
    acc = '0;
    for (int i = 0; i < HDR_WORDS; i++) begin
      span = {shadow_key[i], shadow_key[i+1]};
      for (int j = 0; j < 32; j++) begin
        if (words[i][j]) acc = acc ^ 32'(span >> (32 - j));
      end
    end
    return acc;
  endfunction

  function automatic steer_t steer_header(input header_t h);
    steer_t r;
    int     eff_nq;
    r.queue = '0;
    r.hash  = '0;
    if (h.cls == CLASS_TCP || h.cls == CLASS_UDP) begin
      r.hash = flow_hash(h.src, h.dst, {h.sport, h.dport});
      eff_nq = int'(shadow_nq);
      if (eff_nq == 0) eff_nq = 1;
      if (eff_nq > MAX_QUEUES) eff_nq = MAX_QUEUES;
      r.queue = Q_W'((r.hash % BUCKETS) % eff_nq);
    end
    return r;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < 10) $display("%t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [31:0] rand_word(input int bits);
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(15))
      0: w = '0;
      1: w = '1;
      default: ;
    endcase
    return bits == 32 ? w : w & ((32'd1 << bits) - 1);
  endfunction

  function automatic header_t rand_header();
    header_t h;
    int pick;
    pick = $urandom_range(99);
    if (pick < 42) h.cls = CLASS_TCP;
    else if (pick < 84) h.cls = CLASS_UDP;
    else if (pick < 92) h.cls = CLASS_NON_IP;
    else h.cls = CLASS_OTHER;
    h.src   = rand_word(32);
    h.dst   = rand_word(32);
    h.sport = 16'(rand_word(16));
    h.dport = 16'(rand_word(16));
    return h;
  endfunction

  task automatic send_header(input header_t h);
    @(negedge clk);
    while (tx_gaps && $urandom_range(99) < 37) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = h.cls;
    s_tdata  = {h.dport, h.sport, h.dst, h.src};
    do @(posedge clk); while (!s_tready);
    steer_expected.push_back(steer_header(h));
  endtask

  task automatic send_fields(input logic [1:0] cls, input logic [31:0] src,
                             input logic [31:0] dst, input logic [15:0] sport,
                             input logic [15:0] dport);
    header_t h;
    h.cls   = cls;
    h.src   = src;
    h.dst   = dst;
    h.sport = sport;
    h.dport = dport;
    send_header(h);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_header(rand_header());
  endtask

  // stop offering and let every result out before touching registers
  task automatic wait_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (steer_expected.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_read(input logic [2:0] idx, output logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == REG_NUM_QUEUES) shadow_nq = value[NQ_W-1:0];
    else if (idx <= REG_KEY_WORD3) shadow_key[idx - REG_KEY_WORD0] = value;
    // writes past the last register must leave everything alone
    for (int r = REG_NUM_QUEUES; r <= REG_KEY_WORD3; r++) begin
      apb_read(3'(r), readback);
      want = (r == REG_NUM_QUEUES) ? 32'(shadow_nq) : shadow_key[r - REG_KEY_WORD0];
      if (readback !== want)
        flag_error($sformatf("register %0d reads %h, expected %h", r, readback, want));
    end
  endtask

  task automatic set_keys(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3);
    reg_write(REG_KEY_WORD0, k0);
    reg_write(REG_KEY_WORD1, k1);
    reg_write(REG_KEY_WORD2, k2);
    reg_write(REG_KEY_WORD3, k3);
  endtask

  // receiver: random stalls, plus an optional long hold-off counted here
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        m_tready = 1'b0;
        rx_hold_cycles--;
      end else begin
        m_tready = !(rx_gaps && $urandom_range(99) < 37);
      end
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (steer_expected.size() == 0) begin
          flag_error($sformatf("result with nothing pending: queue %0d hash %h",
                               m_tdata[Q_W-1:0], m_tdata[Q_W +: 32]));
        end else begin
          steer_t want;
          want = steer_expected.pop_front();
          if (m_tdata[Q_W-1:0] !== want.queue || m_tdata[Q_W +: 32] !== want.hash)
            flag_error($sformatf("queue %0d hash %h, expected queue %0d hash %h",
                                 m_tdata[Q_W-1:0], m_tdata[Q_W +: 32], want.queue, want.hash));
        end
      end
    end
  end

  task automatic test_reset_values();
    send_fields(CLASS_NON_IP, '1, '1, '1, '1);
    send_fields(CLASS_TCP,    '1, '1, '1, '1);
    send_fields(CLASS_UDP,    '1, '1, '1, '1);
    send_fields(CLASS_OTHER,  '1, '1, '1, '1);
    send_fields(CLASS_TCP,    '0, '0, '0, '0);
    send_fields(CLASS_UDP,    '0, '0, '0, '0);
    send_fields(CLASS_OTHER,  32'h0a000001, 32'h0a000002, 16'd80, 16'd443);
    send_fields(CLASS_NON_IP, 32'hc0a80001, 32'hc0a80002, 16'd53, 16'd53);
    // single bits at both ends of every word
    send_fields(CLASS_TCP, 32'h00000001, '0, '0, '0);
    send_fields(CLASS_TCP, 32'h80000000, '0, '0, '0);
    send_fields(CLASS_UDP, '0, 32'h00000001, '0, '0);
    send_fields(CLASS_UDP, '0, 32'h80000000, '0, '0);
    send_fields(CLASS_TCP, '0, '0, 16'h8000, 16'h0000);
    send_fields(CLASS_TCP, '0, '0, 16'h0000, 16'h0001);
    send_fields(CLASS_UDP, 32'haaaaaaaa, 32'h55555555, 16'haaaa, 16'h5555);
    send_fields(CLASS_TCP, 32'h55555555, 32'haaaaaaaa, 16'h5555, 16'haaaa);
    send_random(20);
  endtask

  task automatic test_register_sweep();
    for (int phase = 0; phase < 8; phase++) begin
      wait_drain();
      case (phase)
        0: reg_write(REG_NUM_QUEUES, 32'd1);
        1: begin
          reg_write(REG_NUM_QUEUES, 32'd16);
          set_keys('1, '1, '1, '1);
        end
        2: begin
          // zero queues and a zero key
          reg_write(REG_NUM_QUEUES, 32'd0);
          set_keys('0, '0, '0, '0);
        end
        3: begin
          reg_write(REG_NUM_QUEUES, 32'd17);
          set_keys($urandom, $urandom, $urandom, $urandom);
        end
        4: begin
          reg_write(REG_NUM_QUEUES, 32'd31);
          set_keys($urandom, $urandom, $urandom, $urandom);
        end
        5: begin
          // upper bits of pwdata beyond the queue count are dropped
          reg_write(REG_NUM_QUEUES, 32'hffffffe7);
          set_keys(32'h80000001, 32'h00000001, 32'h80000000, 32'h7ffffffe);
        end
        6: begin
          reg_write(REG_NUM_QUEUES, 32'd3);
          set_keys($urandom, $urandom, $urandom, $urandom);
        end
        default: begin
          reg_write(REG_NUM_QUEUES, 32'd5);
          for (int r = REG_KEY_WORD3 + 1; r < 8; r++) reg_write(3'(r), $urandom);
        end
      endcase
      send_random(phase == 2 ? 40 : 110);
    end
  endtask

  task automatic test_output_stall();
    wait_drain();
    reg_write(REG_NUM_QUEUES, 32'd8);
    set_keys($urandom, $urandom, $urandom, $urandom);
    tx_gaps = 1'b0;
    @(posedge clk);
    rx_hold_cycles = 150;
    send_random(60);
    tx_gaps = 1'b1;
    // sender waits for everything to come back before carrying on
    wait_drain();
    send_random(40);
  endtask

  task automatic test_full_rate();
    wait_drain();
    reg_write(REG_NUM_QUEUES, 32'd16);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_random(200);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 3; phase++) begin
      wait_drain();
      reg_write(REG_NUM_QUEUES, $urandom_range(31));
      set_keys($urandom, $urandom, $urandom, $urandom);
      send_random(100);
    end
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    error_count    = 0;
    rx_hold_cycles = 0;
    tx_gaps        = 1'b1;
    rx_gaps        = 1'b1;
    shadow_nq      = NUM_QUEUES_RST;
    shadow_key[0]  = KEY_WORD0_RST;
    shadow_key[1]  = KEY_WORD1_RST;
    shadow_key[2]  = KEY_WORD2_RST;
    shadow_key[3]  = KEY_WORD3_RST;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_register_sweep();
    test_output_stall();
    test_full_rate();
    test_random_mix();

    wait_drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("rss_flow_hash_queue_select_unit_tb: done, clean");
    end else begin
      $display("rss_flow_hash_queue_select_unit_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rss_flow_hash_queue_select_unit_tb: done, errors");
    $finish;
  end

endmodule
